### rtl/cpr_pkg.sv
// shared constants, types and controller states for the clock page replacement unit
// no dependencies
package cpr_pkg;

    localparam int CPR_FRAMES    = 8;
    localparam int CPR_PAGE_BITS = 20;
    localparam int CFG_W         = 4;
    localparam int FIDX_W        = 3;
    localparam int FAULT_W       = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd7;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_SWEEP  = 5'b00100,
        S_WRITE  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch page, reset lookup scan
        logic lookup;    // step the lookup scan
        logic take_hit;  // record the hit frame
        logic miss;      // lookup ended without a match, fix up the hand
        logic sweep;     // step the hand over set reference bits
        logic commit;    // place the page in the victim frame
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit_found;
        logic scan_miss;
        logic ref_at_hand;
        logic out_free;
    } t_sts;

endpackage

### rtl/cpr_ctrl.sv
// controller state machine for the clock page replacement unit
// depends on cpr_pkg
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_sts.hit_found) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.scan_miss) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                // victim read goes out at the hand in the cycle the bit is seen clear
                if (!i_sts.ref_at_hand) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/cpr_datapath.sv
// frame store, reference bits, clock hand, fault counter and result registers
// depends on cpr_pkg
module cpr_datapath
    import cpr_pkg::*;
#(
    parameter int FRAMES    = CPR_FRAMES,
    parameter int PAGE_BITS = CPR_PAGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_total
);

    localparam int HW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] mem_page [FRAMES];
    logic [PAGE_BITS-1:0] r_rd_data;
    logic [HW-1:0]        rd_addr;

    logic [CFG_W-1:0]     r_cfg;
    logic [FRAMES-1:0]    r_valid;
    logic [FRAMES-1:0]    r_ref;
    logic [HW-1:0]        r_hand;
    logic [FAULT_W-1:0]   r_faults;
    logic [PAGE_BITS-1:0] r_page;
    logic [CW-1:0]        r_nfr;
    logic [CW-1:0]        r_scan;
    logic                 r_cmp_vld;
    logic [HW-1:0]        r_cmp_idx;
    logic [HW-1:0]        r_slot;
    logic                 r_hit;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [HW-1:0]        r_out_slot;
    logic                 r_out_ev_valid;
    logic [PAGE_BITS-1:0] r_out_ev_page;
    logic [FAULT_W-1:0]   r_out_faults;

    logic [CW-1:0] n_nfr;
    logic [HW-1:0] n_hand_step;
    logic [HW-1:0] n_hand_after;
    logic          scan_issue;
    logic          hit_now;

    // active frame count clamped to one..FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            n_nfr = CW'(1);
        end else if (32'(r_cfg) > FRAMES) begin
            n_nfr = CW'(FRAMES);
        end else begin
            n_nfr = CW'(r_cfg);
        end
    end

    assign n_hand_step  = ((CW'(r_hand) + CW'(1)) == r_nfr) ? '0 : r_hand + HW'(1);
    assign n_hand_after = ((CW'(r_slot) + CW'(1)) == r_nfr) ? '0 : r_slot + HW'(1);

    assign scan_issue = i_cmd.lookup && (r_scan < r_nfr);
    assign rd_addr    = i_cmd.lookup ? r_scan[HW-1:0] : r_hand;
    assign hit_now    = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_page);

    assign o_sts.hit_found   = hit_now;
    assign o_sts.scan_miss   = r_cmp_vld && !hit_now
                               && ((CW'(r_cmp_idx) + CW'(1)) == r_nfr);
    assign o_sts.ref_at_hand = r_ref[r_hand];
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    // page store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem_page[rd_addr];
        if (i_cmd.commit) begin
            mem_page[r_slot] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RESET;
            r_valid   <= '0;
            r_ref     <= '0;
            r_hand    <= '0;
            r_faults  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.start) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.lookup) begin
                r_cmp_vld <= scan_issue;
            end
            if (i_cmd.take_hit) begin
                r_ref[r_cmp_idx] <= 1'b1;
            end
            // a hand left outside a shrunken range restarts at frame zero
            if (i_cmd.miss && (CW'(r_hand) >= r_nfr)) begin
                r_hand <= '0;
            end
            if (i_cmd.sweep && r_ref[r_hand]) begin
                r_ref[r_hand] <= 1'b0;
                r_hand        <= n_hand_step;
            end
            if (i_cmd.commit) begin
                r_valid[r_slot] <= 1'b1;
                r_ref[r_slot]   <= 1'b1;
                r_hand          <= n_hand_after;
                if (r_faults != FAULT_MAX) begin
                    r_faults <= r_faults + FAULT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page <= i_page_number;
            r_nfr  <= n_nfr;
            r_scan <= '0;
        end else if (scan_issue) begin
            r_scan    <= r_scan + CW'(1);
            r_cmp_idx <= r_scan[HW-1:0];
        end
        if (i_cmd.take_hit) begin
            r_hit      <= 1'b1;
            r_slot     <= r_cmp_idx;
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
        end
        if (i_cmd.sweep && !r_ref[r_hand]) begin
            r_slot <= r_hand;
        end
        if (i_cmd.commit) begin
            r_hit      <= 1'b0;
            r_ev_valid <= r_valid[r_slot];
            r_ev_page  <= r_valid[r_slot] ? r_rd_data : '0;
        end
    end

    // output register, parts the result from the next item's work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit      <= r_hit;
            r_out_slot     <= r_slot;
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_page  <= r_ev_page;
            r_out_faults   <= r_faults;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = FIDX_W'(r_out_slot);
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_faults;

endmodule

### rtl/clock_page_replacement_unit.sv
// Second-chance (clock) page replacement over FRAMES page frames. One page reference per
// input item, one result item per reference. With n the active frame count, a lookup walks
// the first n frames of the page store, one frame a cycle through its single read port,
// until it finds the page; a miss then sweeps the hand, clearing each set reference bit it
// passes, to the first frame with a clear bit and places the page there. A stalled output
// register keeps the result waiting. One item is in work at a time; the next is accepted
// as soon as the result is in the output register. The fault counter saturates at its
// all-ones value.
// top level; depends on cpr_pkg, cpr_ctrl and cpr_datapath
module clock_page_replacement_unit
    import cpr_pkg::*;
#(
    parameter int FRAMES    = CPR_FRAMES,
    parameter int PAGE_BITS = CPR_PAGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_total
);

    t_cmd cmd;
    t_sts sts;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_page_number   (i_page_number),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

endmodule
